// File: design/rfs_pkg.sv
`default_nettype none
package rfs_pkg;

  localparam int unsigned NCH        = 3;
  localparam int unsigned LVL_W      = 10;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned TICK_W     = 10;
  localparam int unsigned DWELL_W    = 16;
  localparam int unsigned TMO_W      = 24;
  localparam int unsigned ELAP_W     = 32;
  localparam int unsigned PKT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  localparam logic [LVL_W-1:0]   LEVEL_MAX  = 10'd1023;
  localparam logic [IDX_W-1:0]   COLOR_NONE = 3'd7;
  localparam logic [STEP_W-1:0]  STEP_MIN   = 3'd1;

  localparam logic [TICK_W-1:0]  TICK_MS_RST    = 10'd20;
  localparam logic [DWELL_W-1:0] DWELL_MS_RST   = 16'd2000;
  localparam logic [TMO_W-1:0]   TIMEOUT_MS_RST = 24'd3600000;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_DWELL = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_MS    = 2'd0,
    CFG_DWELL_MS   = 2'd1,
    CFG_TIMEOUT_MS = 2'd2
  } cfg_idx_t;

  typedef logic [NCH-1:0][LVL_W-1:0]  lvl_vec_t;
  typedef logic [NCH-1:0][STEP_W-1:0] step_vec_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] color_index;
    step_vec_t        steps;
  } item_t;

  typedef struct packed {
    lvl_vec_t         levels;
    logic [PKT_W-1:0] packet_word;
    logic             packet_valid;
    logic             settled;
    logic             sleep_request;
  } result_t;

  typedef struct packed {
    logic [TICK_W-1:0]  tick_ms;
    logic [DWELL_W-1:0] dwell_ms;
    logic [TMO_W-1:0]   timeout_ms;
  } cfg_t;

  // entries packed blue, green, red from high to low
  function automatic lvl_vec_t color_lookup(input logic [IDX_W-1:0] idx);
    lvl_vec_t v;
    case (idx)
      3'd0:    v = {10'd1023, 10'd723,  10'd523};
      3'd1:    v = {10'd0,    10'd0,    10'd1023};
      3'd2:    v = {10'd1023, 10'd0,    10'd0};
      3'd3:    v = {10'd0,    10'd723,  10'd1023};
      3'd4:    v = {10'd1023, 10'd723,  10'd0};
      3'd5:    v = {10'd1023, 10'd0,    10'd323};
      3'd6:    v = {10'd0,    10'd1023, 10'd0};
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [ELAP_W-1:0] sat_add(input logic [ELAP_W-1:0] a,
                                                input logic [ELAP_W-1:0] b);
    logic [ELAP_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ELAP_W] ? '1 : s[ELAP_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: design/rfs_if.sv
`default_nettype none
interface rfs_in_if;
  import rfs_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [IDX_W-1:0]  color_index;
  logic [STEP_W-1:0] step_red;
  logic [STEP_W-1:0] step_green;
  logic [STEP_W-1:0] step_blue;
  modport source (output valid, cmd, color_index, step_red, step_green, step_blue,
                  input ready);
  modport sink   (input valid, cmd, color_index, step_red, step_green, step_blue,
                  output ready);
endinterface

interface rfs_out_if;
  import rfs_pkg::*;
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] level_red;
  logic [LVL_W-1:0] level_green;
  logic [LVL_W-1:0] level_blue;
  logic [PKT_W-1:0] packet_word;
  logic             packet_valid;
  logic             settled;
  logic             sleep_request;
  modport source (output valid, level_red, level_green, level_blue, packet_word,
                  packet_valid, settled, sleep_request, input ready);
  modport sink   (input valid, level_red, level_green, level_blue, packet_word,
                  packet_valid, settled, sleep_request, output ready);
endinterface

interface rfs_cfg_if;
  import rfs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: design/rfs_cfg_regs.sv
`default_nettype none
module rfs_cfg_regs (
  input  wire           clk,
  input  wire           rst_n,
  rfs_cfg_if.sink       cfg_ch,
  output rfs_pkg::cfg_t cfg
);
  import rfs_pkg::*;

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg         = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_ms    <= TICK_MS_RST;
      cfg_r.dwell_ms   <= DWELL_MS_RST;
      cfg_r.timeout_ms <= TIMEOUT_MS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_TICK_MS:    cfg_r.tick_ms    <= cfg_ch.data[TICK_W-1:0];
        CFG_DWELL_MS:   cfg_r.dwell_ms   <= cfg_ch.data[DWELL_W-1:0];
        CFG_TIMEOUT_MS: cfg_r.timeout_ms <= cfg_ch.data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/rfs_core.sv
`default_nettype none
module rfs_core (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              fire,
  input  rfs_pkg::item_t   item,
  input  rfs_pkg::cfg_t    cfg,
  output rfs_pkg::result_t res
);
  import rfs_pkg::*;

  lvl_vec_t            cur_r, cur_nxt;
  lvl_vec_t            tgt_r, tgt_nxt;
  step_vec_t           step_r, step_nxt;
  logic [NCH-1:0]      down_r, down_nxt;
  logic [LVL_W-1:0]    ramp_r, ramp_nxt;
  logic [ELAP_W-1:0]   elapsed_r, elapsed_nxt;
  logic                asleep_r, asleep_nxt;

  lvl_vec_t            table_lvl;
  lvl_vec_t            moved;
  lvl_vec_t            clamped;
  logic signed [LVL_W:0] gap [NCH];
  logic [LVL_W-1:0]    ramp_inc;
  logic                ramp_active;
  logic                timed_out;
  logic                settled_now;
  logic                pkt_valid;

  assign table_lvl   = color_lookup(item.color_index);
  assign timed_out   = elapsed_r > {{(ELAP_W-TMO_W){1'b0}}, cfg.timeout_ms};
  assign settled_now = (cur_r == tgt_r);
  assign ramp_active = (ramp_r != LEVEL_MAX);
  assign ramp_inc    = ramp_r + 1'b1;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      gap[c] = down_r[c] ? ($signed({1'b0, cur_r[c]}) - $signed({1'b0, tgt_r[c]}))
                         : ($signed({1'b0, tgt_r[c]}) - $signed({1'b0, cur_r[c]}));
      if (cur_r[c] == tgt_r[c]) begin
        moved[c] = cur_r[c];
      end else if (gap[c] < $signed({{(LVL_W+1-STEP_W){1'b0}}, step_r[c]})) begin
        moved[c] = tgt_r[c];
      end else if (down_r[c]) begin
        moved[c] = cur_r[c] - {{(LVL_W-STEP_W){1'b0}}, step_r[c]};
      end else begin
        moved[c] = cur_r[c] + {{(LVL_W-STEP_W){1'b0}}, step_r[c]};
      end
      clamped[c] = (ramp_active && moved[c] > ramp_inc) ? ramp_inc : moved[c];
    end
  end

  always_comb begin
    cur_nxt     = cur_r;
    tgt_nxt     = tgt_r;
    step_nxt    = step_r;
    down_nxt    = down_r;
    ramp_nxt    = ramp_r;
    elapsed_nxt = elapsed_r;
    asleep_nxt  = asleep_r;
    pkt_valid   = 1'b0;
    case (cmd_t'(item.cmd))
      CMD_LOAD: begin
        for (int c = 0; c < NCH; c++) begin
          if (item.color_index != COLOR_NONE) begin
            tgt_nxt[c] = table_lvl[c];
          end
          if (timed_out) begin
            tgt_nxt[c] = '0;
          end
          step_nxt[c] = (item.steps[c] == '0) ? STEP_MIN : item.steps[c];
          down_nxt[c] = tgt_nxt[c] < cur_r[c];
        end
      end
      CMD_TICK: begin
        if (!settled_now) begin
          cur_nxt     = clamped;
          ramp_nxt    = ramp_active ? ramp_inc : ramp_r;
          pkt_valid   = 1'b1;
          elapsed_nxt = sat_add(elapsed_r, {{(ELAP_W-TICK_W){1'b0}}, cfg.tick_ms});
        end
      end
      CMD_DWELL: begin
        if (tgt_r == '0 && settled_now && timed_out) begin
          asleep_nxt = 1'b1;
        end
        elapsed_nxt = sat_add(elapsed_r, {{(ELAP_W-DWELL_W){1'b0}}, cfg.dwell_ms});
      end
      default: ;
    endcase
  end

  always_comb begin
    res.levels        = cur_nxt;
    res.packet_word   = pkt_valid ? {2'b00, cur_nxt[CH_BLUE], cur_nxt[CH_RED],
                                     cur_nxt[CH_GREEN]} : '0;
    res.packet_valid  = pkt_valid;
    res.settled       = (cur_nxt == tgt_nxt);
    res.sleep_request = asleep_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= '0;
      tgt_r     <= '0;
      step_r    <= {NCH{STEP_MIN}};
      down_r    <= '0;
      ramp_r    <= '0;
      elapsed_r <= '0;
      asleep_r  <= 1'b0;
    end else if (fire) begin
      cur_r     <= cur_nxt;
      tgt_r     <= tgt_nxt;
      step_r    <= step_nxt;
      down_r    <= down_nxt;
      ramp_r    <= ramp_nxt;
      elapsed_r <= elapsed_nxt;
      asleep_r  <= asleep_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/rgb_fade_stepper_top.sv
// Three-channel LED fader with soft start and sleep timeout.
// in_ch carries one command word: load a target colour, take a fade tick
// or take a dwell pause. out_ch returns exactly one result word per input
// word: the three levels, the 4-byte packet word and its valid flag, the
// settled flag and the sticky sleep request.
// cfg_ch writes tick_ms (index 0), dwell_ms (1) and timeout_ms (2); it is
// always ready and should be used only while no word is in flight.
// The accepted word waits in the input register; once the result register
// is free, the fader state and the result register update together on the
// same edge, and the result word is offered from that edge on. Throughput is
// one word per cycle while the receiver does not stall; the fade arithmetic
// on the three channels is a single pass of small adds and compares.
// When the receiver stalls, the result register holds and the input register
// fills; in_ch.ready drops only when both hold a word. At reset (rst_n low,
// synchronous) levels, targets and elapsed time clear, steps go to 1 and the
// registers return to 20 ms, 2000 ms and 3600000 ms.
`default_nettype none
module rgb_fade_stepper_top (
  input  wire        clk,
  input  wire        rst_n,
  rfs_in_if.sink     in_ch,
  rfs_out_if.source  out_ch,
  rfs_cfg_if.sink    cfg_ch
);
  import rfs_pkg::*;

  logic    in_v_r;
  item_t   item_r;
  logic    out_v_r;
  result_t res_r;
  result_t res;
  cfg_t    cfg;
  logic    advance;

  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;

  rfs_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  rfs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.cmd         <= in_ch.cmd;
      item_r.color_index <= in_ch.color_index;
      item_r.steps       <= {in_ch.step_blue, in_ch.step_green, in_ch.step_red};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.level_red     = res_r.levels[CH_RED];
  assign out_ch.level_green   = res_r.levels[CH_GREEN];
  assign out_ch.level_blue    = res_r.levels[CH_BLUE];
  assign out_ch.packet_word   = res_r.packet_word;
  assign out_ch.packet_valid  = res_r.packet_valid;
  assign out_ch.settled       = res_r.settled;
  assign out_ch.sleep_request = res_r.sleep_request;

endmodule
`default_nettype wire
